>>> hw/rtl/lfu_page_replacement_assert.svh
// assertion macros for the checker file of the lfu page replacement block
// depends on nothing; every macro expects clk_i and rst_ni in scope
`ifndef LFU_PAGE_REPLACEMENT_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LFU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LFU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lfu_pkg.sv
// package of the lfu page replacement block: field widths, defaults, scan control type
// depends on nothing; used by lfu_scan and lfu_page_replacement
package lfu_pkg;

  localparam int FRAME_COUNT_DEF = 16;
  localparam int PAGE_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int FAULT_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  // control of the shared compare unit for one frame of the scan
  typedef struct packed {
    logic clear;  // new request, drop the previous hit
    logic step;   // a frame word is on the read port
    logic first;  // that word belongs to frame zero
  } scan_ctl_t;

endpackage

>>> hw/rtl/lfu_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module lfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lfu_scan.sv
// shared compare unit: one frame per step, tracks first hit and least-used frame
// depends on lfu_pkg
module lfu_scan
  import lfu_pkg::*;
#(
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int IDX_W      = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_ctl_t             ctl_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [PAGE_BITS-1:0]  page_i,
  input  logic                  valid_i,
  input  logic [PAGE_BITS-1:0]  tag_i,
  input  logic [COUNT_BITS-1:0] cnt_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      hit_idx_o,
  output logic [COUNT_BITS-1:0] hit_cnt_o,
  output logic [IDX_W-1:0]      victim_o,
  output logic                  victim_valid_o,
  output logic [PAGE_BITS-1:0]  victim_tag_o
);

  logic                  found_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic [COUNT_BITS-1:0] min_q;
  logic [IDX_W-1:0]      victim_q;
  logic                  victim_valid_q;
  logic [PAGE_BITS-1:0]  victim_tag_q;
  logic [COUNT_BITS-1:0] eff_cnt;
  logic                  is_hit;
  logic                  is_min;

  // empty frames weigh as zero uses
  assign eff_cnt = valid_i ? cnt_i : '0;
  assign is_hit  = !found_q && valid_i && (tag_i == page_i);
  assign is_min  = ctl_i.first || (eff_cnt < min_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctl_i.step && is_hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step && is_hit) begin
      hit_idx_q <= idx_i;
      hit_cnt_q <= cnt_i;
    end
    if (ctl_i.step && is_min) begin
      min_q          <= eff_cnt;
      victim_q       <= idx_i;
      victim_valid_q <= valid_i;
      victim_tag_q   <= tag_i;
    end
  end

  assign found_o        = found_q;
  assign hit_idx_o      = hit_idx_q;
  assign hit_cnt_o      = hit_cnt_q;
  assign victim_o       = victim_q;
  assign victim_valid_o = victim_valid_q;
  assign victim_tag_o   = victim_tag_q;

endmodule

>>> hw/rtl/lfu_page_replacement.sv
// top level of the lfu page replacement block: sequencer, frame ram, valid bits, results
// depends on lfu_pkg, lfu_ram, lfu_scan
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------------
//   cfg     | in        | cfg_we_i (no wait)       | cfg_wdata_i (active_frames)
//   in      | in        | in_valid_i / in_ready_o  | page_i
//   out     | out       | out_valid_o / out_ready_i| hit_o slot_o evicted_valid_o
//           |           |                          | evicted_page_o fault_total_o
//
// a request runs from accept to the next in_ready_o through one ram read per active frame
// via the shared compare unit, one drain and one write-back
// reset leaves all frames empty, active_frames 16 and the fault count at zero
// the result sits in an output register; a new request is taken while it waits, and
// write-back stalls only when the previous result has not been taken yet
module lfu_page_replacement
  import lfu_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PAGE_W-1:0]  page_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               evicted_valid_o,
  output logic [PAGE_W-1:0]  evicted_page_o,
  output logic [FAULT_W-1:0] fault_total_o
);

  localparam int IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int WORD_W = PAGE_BITS + COUNT_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CFG_W-1:0]       active_q;
  logic [IDX_W-1:0]       last_d, last_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic [IDX_W-1:0]       cmp_idx_q;
  logic                   cmp_vld_q;
  logic [PAGE_BITS-1:0]   page_q;
  logic [FRAME_COUNT-1:0] valid_q;
  logic [FAULT_W-1:0]     fault_q, fault_d;

  logic                   in_acc;
  logic                   out_free;
  logic                   wb_go;
  scan_ctl_t              scan_ctl;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic                   ram_re;
  logic [WORD_W-1:0]      ram_rdata;

  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic [COUNT_BITS-1:0]  hit_cnt;
  logic [IDX_W-1:0]       victim;
  logic                   victim_valid;
  logic [PAGE_BITS-1:0]   victim_tag;
  logic [COUNT_BITS-1:0]  hit_cnt_inc;
  logic                   evict;

  logic                   out_valid_q;
  logic                   hit_q;
  logic [SLOT_W-1:0]      slot_q;
  logic                   ev_valid_q;
  logic [PAGE_W-1:0]      ev_page_q;
  logic [FAULT_W-1:0]     fault_out_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign wb_go      = (state_q == ST_WRITE) && out_free;

  // zero active frames acts as one, anything above the frame count as the frame count
  always_comb begin
    if (active_q == '0) begin
      last_d = '0;
    end else if (int'(active_q) > FRAME_COUNT) begin
      last_d = IDX_W'(FRAME_COUNT - 1);
    end else begin
      last_d = IDX_W'(active_q - 5'd1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      active_q  <= ACTIVE_RESET;
      valid_q   <= '0;
      fault_q   <= '0;
      cmp_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (wb_go) begin
        fault_q <= fault_d;
        if (!found) begin
          valid_q[victim] <= 1'b1;
        end
      end
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      page_q   <= PAGE_BITS'(page_i);
      last_q   <= last_d;
      rd_idx_q <= '0;
    end else if (state_q == ST_SCAN) begin
      rd_idx_q <= IDX_W'(rd_idx_q + 1'b1);
    end
    cmp_idx_q <= rd_idx_q;
    if (wb_go) begin
      hit_q       <= found;
      slot_q      <= SLOT_W'(found ? hit_idx : victim);
      ev_valid_q  <= evict;
      ev_page_q   <= evict ? PAGE_W'(victim_tag) : '0;
      fault_out_q <= fault_d;
    end
  end

  assign scan_ctl.clear = in_acc;
  assign scan_ctl.step  = cmp_vld_q;
  assign scan_ctl.first = (cmp_idx_q == '0);

  assign ram_re    = (state_q == ST_SCAN);
  assign ram_we    = wb_go;
  assign ram_waddr = found ? hit_idx : victim;
  assign ram_wdata = found ? {page_q, hit_cnt_inc} : {page_q, COUNT_BITS'(1)};

  assign hit_cnt_inc = (&hit_cnt) ? hit_cnt : COUNT_BITS'(hit_cnt + 1'b1);
  assign evict       = !found && victim_valid;
  assign fault_d     = (found || (&fault_q)) ? fault_q : FAULT_W'(fault_q + 1'b1);

  lfu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAME_COUNT),
    .AW    (IDX_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  lfu_scan #(
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (scan_ctl),
    .idx_i          (cmp_idx_q),
    .page_i         (page_q),
    .valid_i        (valid_q[cmp_idx_q]),
    .tag_i          (ram_rdata[WORD_W-1:COUNT_BITS]),
    .cnt_i          (ram_rdata[COUNT_BITS-1:0]),
    .found_o        (found),
    .hit_idx_o      (hit_idx),
    .hit_cnt_o      (hit_cnt),
    .victim_o       (victim),
    .victim_valid_o (victim_valid),
    .victim_tag_o   (victim_tag)
  );

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = fault_out_q;

endmodule

>>> hw/rtl/lfu_page_replacement_chk.sv
// port-level checker for lfu_page_replacement, bound to the top level
// depends on lfu_page_replacement_assert.svh and lfu_pkg
`include "lfu_page_replacement_assert.svh"

module lfu_page_replacement_chk
  import lfu_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [CFG_W-1:0]   cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [PAGE_W-1:0]  page_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               hit_o,
  input logic [SLOT_W-1:0]  slot_o,
  input logic               evicted_valid_o,
  input logic [PAGE_W-1:0]  evicted_page_o,
  input logic [FAULT_W-1:0] fault_total_o
);

  // a result stays until taken
  `LFU_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(fault_total_o), "result dropped before taken")

  // the block is not ready in the cycle after it accepts a request
  `LFU_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready right after a request")

  // a hit never evicts
  `LFU_ASSERT_IMP(a_hit_no_evict, out_valid_o && hit_o, !evicted_valid_o && (evicted_page_o == '0), "hit reports an eviction")

  // no eviction means no evicted page and a fault never leaves the count at zero
  `LFU_ASSERT_IMP(a_evict_page, out_valid_o && !hit_o, (fault_total_o != '0) && (evicted_valid_o || (evicted_page_o == '0)), "fault result inconsistent")

endmodule

bind lfu_page_replacement lfu_page_replacement_chk u_chk (.*);

>>> tb/sv/lfu_page_replacement_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the lfu page replacement block: page requests, frame results
// depends on lfu_pkg and the lfu_page_replacement rtl; holds its own model of the frame set
module lfu_page_replacement_tb;
  import lfu_pkg::*;

  localparam int          NUM_FRAMES  = FRAME_COUNT_DEF;
  localparam logic [15:0] USE_MAX     = 16'hFFFF;
  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam int          NUM_PHASES  = 12;
  localparam int          PHASE_REQS  = 140;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] faults;
  } frame_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [PAGE_W-1:0]  page_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               hit_o;
  logic [SLOT_W-1:0]  slot_o;
  logic               evicted_valid_o;
  logic [PAGE_W-1:0]  evicted_page_o;
  logic [FAULT_W-1:0] fault_total_o;

  lfu_page_replacement uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_i          (page_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model of the frame set
  logic [PAGE_W-1:0]  tag_m   [NUM_FRAMES];
  logic [15:0]        uses_m  [NUM_FRAMES];
  logic               valid_m [NUM_FRAMES];
  logic [FAULT_W-1:0] faults_m;
  logic [CFG_W-1:0]   active_m;

  logic [PAGE_W-1:0] pending_pages[$];
  frame_result_t     expected_results[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_cnt;
  int cycle_cnt;

  initial begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      tag_m[i] = '0;
      uses_m[i] = '0;
      valid_m[i] = 1'b0;
    end
    faults_m = '0;
    active_m = ACTIVE_RESET;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 14;
    recv_idle_pct = 80;
  end

  function automatic frame_result_t reference_page(logic [PAGE_W-1:0] page);
    frame_result_t r;
    int n;
    int hit_at;
    int victim;
    bit found;
    logic [15:0] min_use;
    logic [15:0] use_now;
    n = int'(active_m);
    if (n < 1) n = 1;
    if (n > NUM_FRAMES) n = NUM_FRAMES;
    found = 1'b0;
    hit_at = 0;
    victim = 0;
    min_use = '0;
    for (int i = 0; i < n; i++) begin
      use_now = valid_m[i] ? uses_m[i] : 16'd0;
      if (!found && valid_m[i] && tag_m[i] == page) begin
        found = 1'b1;
        hit_at = i;
      end
      if (i == 0 || use_now < min_use) begin
        min_use = use_now;
        victim = i;
      end
    end
    r = '0;
    if (found) begin
      if (uses_m[hit_at] != USE_MAX) uses_m[hit_at] = uses_m[hit_at] + 16'd1;
      r.hit = 1'b1;
      r.slot = SLOT_W'(hit_at);
    end else begin
      if (valid_m[victim]) begin
        r.ev_valid = 1'b1;
        r.ev_page = tag_m[victim];
      end
      tag_m[victim] = page;
      uses_m[victim] = 16'd1;
      valid_m[victim] = 1'b1;
      if (faults_m != '1) faults_m = faults_m + 1'b1;
      r.slot = SLOT_W'(victim);
    end
    r.faults = faults_m;
    return r;
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_cnt++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  // request driver: valid holds until accepted, next page taken from the pending queue
  always @(posedge clk_i) begin : drive_requests
    logic              nxt_valid;
    logic [PAGE_W-1:0] nxt_page;
    nxt_valid = in_valid_i;
    nxt_page = page_i;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(reference_page(page_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_pages.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_page = pending_pages.pop_front();
      end
    end
    in_valid_i <= nxt_valid;
    page_i <= nxt_page;
  end

  // result monitor
  always @(posedge clk_i) begin : check_results
    frame_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        $error("result with no request outstanding");
      end else begin
        e = expected_results.pop_front();
        if (hit_o !== e.hit) note_mismatch("hit", 32'(e.hit), 32'(hit_o));
        if (slot_o !== e.slot) note_mismatch("slot", 32'(e.slot), 32'(slot_o));
        if (evicted_valid_o !== e.ev_valid)
          note_mismatch("evicted_valid", 32'(e.ev_valid), 32'(evicted_valid_o));
        if (evicted_page_o !== e.ev_page)
          note_mismatch("evicted_page", 32'(e.ev_page), 32'(evicted_page_o));
        if (fault_total_o !== e.faults)
          note_mismatch("fault_total", e.faults, fault_total_o);
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // idle on consecutive edges, so a page popped by the driver on the first one is seen
  task automatic wait_drained();
    int calm;
    calm = 0;
    while (calm < 2) begin
      @(posedge clk_i);
      if (pending_pages.size() == 0 && !in_valid_i && expected_results.size() == 0)
        calm++;
      else
        calm = 0;
    end
  endtask

  task automatic write_active_frames(logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    active_m = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PAGE_W-1:0] fill_pages[14];
    logic [PAGE_W-1:0] page_pool[24];
    int phase_cfg[NUM_PHASES];
    int pool_size;
    int in_use;

    fill_pages = '{16'h5555, 16'hAAAA, 16'h8000, 16'h0001, 16'h0F0F, 16'hF0F0, 16'h00FF,
                   16'hFF00, 16'h3C3C, 16'hC3C3, 16'h1111, 16'h2222, 16'h4444, 16'h7FFF};
    phase_cfg = '{1, 0, 31, 17, 16, 2, 15, 4, 9, 16, 1, 7};
    foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // page zero must miss on empty frames even though the model tags start at zero
    pending_pages.push_back(16'h0000);
    pending_pages.push_back(16'h0000);
    repeat (3) pending_pages.push_back(16'hFFFF);
    foreach (fill_pages[i]) pending_pages.push_back(fill_pages[i]);
    // all frames full: evicts the first frame with the lowest count
    pending_pages.push_back(16'h1234);

    // shrink to one frame, load a page that still sits in frame one, grow again:
    // the duplicate in frame zero must win
    write_active_frames(5'd1);
    pending_pages.push_back(16'hFFFF);
    write_active_frames(5'd16);
    pending_pages.push_back(16'hFFFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 14;
        recv_idle_pct = 80;
      end else if (p < 8) begin
        send_idle_pct = 80;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_active_frames(CFG_W'(phase_cfg[p]));
      in_use = phase_cfg[p];
      if (in_use < 1) in_use = 1;
      if (in_use > NUM_FRAMES) in_use = NUM_FRAMES;
      pool_size = in_use + $urandom_range(1, 6);
      // keep part of the pool so old pages stay around across frame count changes
      foreach (page_pool[i])
        if ($urandom_range(99) < 30) page_pool[i] = PAGE_W'($urandom);
      for (int k = 0; k < PHASE_REQS; k++) begin
        if ($urandom_range(99) < 85)
          pending_pages.push_back(page_pool[$urandom_range(pool_size - 1)]);
        else
          pending_pages.push_back(PAGE_W'($urandom));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
